>>> rtl/cslx_pkg.sv
// Shared types, token codes and keyword table for the C subset lexer.
`timescale 1ns / 1ps

package cslx_pkg;

  localparam int NUM_KW      = 9;
  localparam int KW_MAX_LEN  = 6;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] KIND_KEYWORD = 2'd0;
  localparam logic [1:0] KIND_IDENT   = 2'd1;
  localparam logic [1:0] KIND_NUMBER  = 2'd2;
  localparam logic [1:0] KIND_SYMBOL  = 2'd3;

  localparam logic [NUM_KW-1:0] ALL_CAND = '1;

  // one output token
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] kw_idx;
    logic [6:0] len;
    logic [7:0] sym;
    logic       ovf;
    logic       last;
  } tok_rec_t;

  // everything one input byte produced; second is used only when two is set
  typedef struct packed {
    logic     two;
    tok_rec_t first;
    tok_rec_t second;
  } tok_pair_t;

  localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAX_LEN] = '{
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
    '{"f", "l", "o", "a", "t", 8'h00},
    '{"c", "h", "a", "r", 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n"},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00},
    '{"f", "o", "r", 8'h00, 8'h00, 8'h00},
    '{"v", "o", "i", "d", 8'h00, 8'h00}
  };

  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd3, 3'd5, 3'd4, 3'd6, 3'd2, 3'd4, 3'd5, 3'd3, 3'd4
  };

  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    if (pos < 3'(KW_MAX_LEN)) begin
      ch = KW_TEXT[k][pos];
    end
    return ch;
  endfunction

endpackage

>>> rtl/cslx_queue.sv
// Short queue of per-byte token groups between the scanner and the output side.
`timescale 1ns / 1ps

module cslx_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  cslx_pkg::tok_pair_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                pop_valid,
  output cslx_pkg::tok_pair_t pop_data
);

  localparam int PTR_W = $clog2(cslx_pkg::QUEUE_DEPTH);

  cslx_pkg::tok_pair_t mem_r [cslx_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r;
  logic [PTR_W-1:0]    rd_ptr_r;
  logic [PTR_W:0]      count_r;
  logic [PTR_W:0]      count_nxt;

  assign full      = (count_r == (PTR_W+1)'(cslx_pkg::QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/cslx_front.sv
// Scanner: classifies each byte, tracks the current word or number, builds tokens.
`timescale 1ns / 1ps

module cslx_front #(
  parameter int MAX_TOKEN_LEN = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [7:0]          char_byte,
  input  logic                end_of_text,
  output logic                push,
  output cslx_pkg::tok_pair_t push_data
);

  localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
  localparam int NKW   = cslx_pkg::NUM_KW;

  typedef enum logic [4:0] {
    M_IDLE    = 5'b00001,
    M_WORD    = 5'b00010,
    M_NUM     = 5'b00100,
    M_SLASH   = 5'b01000,
    M_COMMENT = 5'b10000
  } mode_t;

  typedef struct packed {
    logic               vld;
    cslx_pkg::tok_rec_t rec;
  } slot_t;

  mode_t            mode_r, mode_nxt;
  logic [LEN_W-1:0] run_r, run_nxt;
  logic [NKW-1:0]   cand_r, cand_nxt;
  logic             ovf_r, ovf_nxt;

  slot_t f0, sy, f1;
  logic  is_let, is_dig, is_sym;
  logic  two;

  function automatic logic [NKW-1:0] keep_mask(input logic [LEN_W-1:0] pos,
                                               input logic [7:0] c);
    logic [NKW-1:0] m;
    for (int k = 0; k < NKW; k++) begin
      m[k] = (pos < LEN_W'(cslx_pkg::KW_LEN[k])) &&
             (cslx_pkg::kw_char(4'(k), pos[2:0]) == c);
    end
    return m;
  endfunction

  function automatic logic [6:0] len7(input logic [LEN_W-1:0] run);
    logic [LEN_W+6:0] w;
    w = {7'b0, run};
    return w[6:0];
  endfunction

  // token for whatever is pending in the given state
  function automatic slot_t flush(input mode_t m, input logic [LEN_W-1:0] run,
                                  input logic [NKW-1:0] cand, input logic ovf);
    slot_t s;
    s = '0;
    if (m == M_WORD) begin
      s.vld      = 1'b1;
      s.rec.kind = cslx_pkg::KIND_IDENT;
      s.rec.len  = len7(run);
      s.rec.ovf  = ovf;
      if (!ovf) begin
        for (int k = 0; k < NKW; k++) begin
          if (cand[k] && (run == LEN_W'(cslx_pkg::KW_LEN[k]))) begin
            s.rec.kind   = cslx_pkg::KIND_KEYWORD;
            s.rec.kw_idx = 4'(k);
          end
        end
      end
    end else if (m == M_NUM) begin
      s.vld      = 1'b1;
      s.rec.kind = cslx_pkg::KIND_NUMBER;
      s.rec.len  = len7(run);
      s.rec.ovf  = ovf;
    end else if (m == M_SLASH) begin
      s.vld      = 1'b1;
      s.rec.kind = cslx_pkg::KIND_SYMBOL;
      s.rec.len  = 7'd1;
      s.rec.sym  = "/";
    end
    return s;
  endfunction

  assign is_let = ((char_byte >= "a") && (char_byte <= "z")) ||
                  ((char_byte >= "A") && (char_byte <= "Z")) || (char_byte == "_");
  assign is_dig = (char_byte >= "0") && (char_byte <= "9");
  assign is_sym = (char_byte == "+") || (char_byte == "-") || (char_byte == "*") ||
                  (char_byte == "(") || (char_byte == ")") || (char_byte == "{") ||
                  (char_byte == "}");

  always_comb begin
    logic do_idle;
    logic do_ext;
    do_idle  = 1'b0;
    do_ext   = 1'b0;
    mode_nxt = mode_r;
    run_nxt  = run_r;
    cand_nxt = cand_r;
    ovf_nxt  = ovf_r;
    f0 = '0;
    sy = '0;
    f1 = '0;

    unique case (mode_r)
      M_WORD: begin
        if (is_let || is_dig) begin
          do_ext = 1'b1;
        end else begin
          f0      = flush(mode_r, run_r, cand_r, ovf_r);
          do_idle = 1'b1;
        end
      end
      M_NUM: begin
        if (is_dig) begin
          do_ext = 1'b1;
        end else begin
          f0      = flush(mode_r, run_r, cand_r, ovf_r);
          do_idle = 1'b1;
        end
      end
      M_SLASH: begin
        if (char_byte == "/") begin
          mode_nxt = M_COMMENT;
        end else begin
          f0      = flush(mode_r, run_r, cand_r, ovf_r);
          do_idle = 1'b1;
        end
      end
      M_COMMENT: begin
        if (char_byte == 8'h0A) begin
          mode_nxt = M_IDLE;
        end
      end
      M_IDLE:  do_idle = 1'b1;
      default: do_idle = 1'b1;
    endcase

    if (do_ext) begin
      cand_nxt = cand_r & keep_mask(run_r, char_byte);
      if (run_r >= LEN_W'(MAX_TOKEN_LEN)) begin
        ovf_nxt = 1'b1;
      end else begin
        run_nxt = run_r + 1'b1;
      end
    end

    if (do_idle) begin
      mode_nxt = M_IDLE;
      run_nxt  = '0;
      cand_nxt = cslx_pkg::ALL_CAND;
      ovf_nxt  = 1'b0;
      if (is_let || is_dig) begin
        mode_nxt = is_let ? M_WORD : M_NUM;
        run_nxt  = LEN_W'(1);
        cand_nxt = keep_mask('0, char_byte);
      end else if (char_byte == "/") begin
        mode_nxt = M_SLASH;
      end else if (is_sym) begin
        sy.vld      = 1'b1;
        sy.rec.kind = cslx_pkg::KIND_SYMBOL;
        sy.rec.len  = 7'd1;
        sy.rec.sym  = char_byte;
      end
    end

    // end of text: drop an open comment, flush anything else
    if (end_of_text) begin
      f1       = flush(mode_nxt, run_nxt, cand_nxt, ovf_nxt);
      mode_nxt = M_IDLE;
      run_nxt  = '0;
      cand_nxt = cslx_pkg::ALL_CAND;
      ovf_nxt  = 1'b0;
    end
  end

  // at most two of the three slots are ever valid
  always_comb begin
    two  = (f0.vld && sy.vld) || (f0.vld && f1.vld) || (sy.vld && f1.vld);
    push = take && (f0.vld || sy.vld || f1.vld);
    push_data.two    = two;
    push_data.first  = f0.vld ? f0.rec : (sy.vld ? sy.rec : f1.rec);
    push_data.second = (f0.vld && sy.vld) ? sy.rec : f1.rec;
    push_data.first.last  = !two;
    push_data.second.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      run_r  <= '0;
      cand_r <= cslx_pkg::ALL_CAND;
      ovf_r  <= 1'b0;
    end else if (take) begin
      mode_r <= mode_nxt;
      run_r  <= run_nxt;
      cand_r <= cand_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule

>>> rtl/cslx_back.sv
// Output side: unpacks token groups into single beats behind an output register.
`timescale 1ns / 1ps

module cslx_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  cslx_pkg::tok_pair_t q_data,
  output logic                q_pop,
  output logic                out_valid,
  output cslx_pkg::tok_rec_t  out_rec,
  input  logic                out_ready
);

  logic               out_vld_r;
  cslx_pkg::tok_rec_t out_rec_r;
  logic               sec_vld_r;
  cslx_pkg::tok_rec_t sec_rec_r;
  logic               load;

  assign load      = !out_vld_r || out_ready;
  assign q_pop     = load && !sec_vld_r && q_valid;
  assign out_valid = out_vld_r;
  assign out_rec   = out_rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      sec_vld_r <= 1'b0;
    end else if (load) begin
      if (sec_vld_r) begin
        out_vld_r <= 1'b1;
        sec_vld_r <= 1'b0;
      end else begin
        out_vld_r <= q_valid;
        sec_vld_r <= q_valid && q_data.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (sec_vld_r) begin
        out_rec_r <= sec_rec_r;
      end else begin
        out_rec_r <= q_data.first;
        sec_rec_r <= q_data.second;
      end
    end
  end

endmodule

>>> rtl/c_subset_lexer.sv
// Top level of the C subset lexer: scanner, token queue and output stage.
`timescale 1ns / 1ps

// Takes one source byte per beat and returns token beats (keyword, identifier,
// number, symbol). A byte is accepted every clock while the four-entry token
// queue has room; the scanner state updates in the same cycle, so bytes can
// stream at one per clock. Results leave through a registered output stage at
// one per clock while out_tready is high, so a byte that yields two tokens (a
// pending token flushed plus a symbol or end-of-text flush) occupies the output
// for both its token beats and the queue soaks up such bursts. An accepted
// byte's first token is written into the queue and then into the output register.
// The final token of each byte's results carries tlast; in_tlast marks the last byte of the text.
module c_subset_lexer #(
  parameter int MAX_TOKEN_LEN = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [3:0] keyword_index, [10:4] token_length,
                                  // [18:11] symbol_char, [19] length_overflow
  output logic [1:0]  out_tuser,  // [1:0] token_kind
  output logic        out_tlast   // last_of_run
);

  logic                take;
  logic                push;
  cslx_pkg::tok_pair_t push_data;
  logic                q_full;
  logic                q_pop;
  logic                q_valid;
  cslx_pkg::tok_pair_t q_data;
  cslx_pkg::tok_rec_t  rec;

  assign in_tready = !q_full;
  assign take      = in_tvalid && in_tready;

  cslx_front #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .char_byte  (in_tdata),
    .end_of_text(in_tlast),
    .push       (push),
    .push_data  (push_data)
  );

  cslx_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (q_pop),
    .pop_valid(q_valid),
    .pop_data (q_data)
  );

  cslx_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .out_valid(out_tvalid),
    .out_rec  (rec),
    .out_ready(out_tready)
  );

  assign out_tdata = {4'b0, rec.ovf, rec.sym, rec.len, rec.kw_idx};
  assign out_tuser = rec.kind;
  assign out_tlast = rec.last;

endmodule

>>> verif/cslx_token_checker.sv
// Token checker for the C subset lexer: predicts token beats from input bytes and compares them.
`timescale 1ns / 1ps

module cslx_token_checker #(
  parameter int MAX_TOKEN_LEN = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  input  logic        in_tlast,   // end_of_text
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // [3:0] keyword_index, [10:4] token_length,
                                  // [18:11] symbol_char, [19] length_overflow
  input  logic [1:0]  out_tuser,  // [1:0] token_kind
  input  logic        out_tlast,  // last_of_run
  output int          fail_count,
  output int          tokens_pending,
  output int          tokens_checked,
  output int          keywords_checked,
  output int          overflows_checked
);

  typedef enum logic [4:0] {
    SCAN_IDLE    = 5'b00001,
    SCAN_WORD    = 5'b00010,
    SCAN_NUMBER  = 5'b00100,
    SCAN_SLASH   = 5'b01000,
    SCAN_COMMENT = 5'b10000
  } scan_mode_t;

  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_LF    = 8'h0A;

  // scanner state mirrored from the block
  scan_mode_t                   scan_mode;
  int                           run_len;
  logic [cslx_pkg::NUM_KW-1:0]  kw_cands;
  logic                         ovf_seen;

  // tokens produced by the byte being scanned
  cslx_pkg::tok_rec_t byte_toks [2];
  int                 byte_tok_cnt;

  cslx_pkg::tok_rec_t tokens_due [$];

  function automatic bit is_letter(logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"], "_"};
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic bit is_symbol(logic [7:0] c);
    return c inside {"+", "-", "*", "(", ")", "{", "}"};
  endfunction

  function automatic int diff_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic add_token(logic [1:0] kind, int kwi, int len, logic [7:0] sym, logic ovf);
    cslx_pkg::tok_rec_t t;
    t.kind   = kind;
    t.kw_idx = 4'(kwi);
    t.len    = 7'(len);
    t.sym    = sym;
    t.ovf    = ovf;
    t.last   = 1'b0;
    byte_toks[byte_tok_cnt] = t;
    byte_tok_cnt++;
  endtask

  // narrow the keyword mask by one character and count it
  task automatic extend_run(logic [7:0] c);
    for (int k = 0; k < cslx_pkg::NUM_KW; k++) begin
      if (run_len < int'(cslx_pkg::KW_LEN[k])) begin
        if (cslx_pkg::KW_TEXT[k][run_len] != c) kw_cands[k] = 1'b0;
      end else begin
        kw_cands[k] = 1'b0;
      end
    end
    if (run_len >= MAX_TOKEN_LEN) begin
      ovf_seen = 1'b1;
    end else begin
      run_len++;
    end
  endtask

  task automatic start_run(scan_mode_t m, logic [7:0] c);
    scan_mode = m;
    run_len   = 0;
    ovf_seen  = 1'b0;
    kw_cands  = cslx_pkg::ALL_CAND;
    extend_run(c);
  endtask

  // emit the pending word, number or held slash and go idle
  task automatic close_token();
    logic [1:0] kind;
    int         kwi;
    if (scan_mode == SCAN_WORD) begin
      kind = cslx_pkg::KIND_IDENT;
      kwi  = 0;
      if (!ovf_seen) begin
        for (int k = 0; k < cslx_pkg::NUM_KW; k++) begin
          if (kw_cands[k] && int'(cslx_pkg::KW_LEN[k]) == run_len) begin
            kind = cslx_pkg::KIND_KEYWORD;
            kwi  = k;
          end
        end
      end
      add_token(kind, kwi, run_len, 8'h00, ovf_seen);
    end else if (scan_mode == SCAN_NUMBER) begin
      add_token(cslx_pkg::KIND_NUMBER, 0, run_len, 8'h00, ovf_seen);
    end else if (scan_mode == SCAN_SLASH) begin
      add_token(cslx_pkg::KIND_SYMBOL, 0, 1, CH_SLASH, 1'b0);
    end
    scan_mode = SCAN_IDLE;
    run_len   = 0;
    ovf_seen  = 1'b0;
    kw_cands  = cslx_pkg::ALL_CAND;
  endtask

  task automatic idle_char(logic [7:0] c);
    if (is_letter(c)) begin
      start_run(SCAN_WORD, c);
    end else if (is_digit(c)) begin
      start_run(SCAN_NUMBER, c);
    end else if (c == CH_SLASH) begin
      scan_mode = SCAN_SLASH;
    end else if (is_symbol(c)) begin
      add_token(cslx_pkg::KIND_SYMBOL, 0, 1, c, 1'b0);
    end else begin
      scan_mode = SCAN_IDLE;
    end
  endtask

  task automatic scan_byte(logic [7:0] c, logic eot);
    byte_tok_cnt = 0;
    case (scan_mode)
      SCAN_WORD: begin
        if (is_letter(c) || is_digit(c)) begin
          extend_run(c);
        end else begin
          close_token();
          idle_char(c);
        end
      end
      SCAN_NUMBER: begin
        if (is_digit(c)) begin
          extend_run(c);
        end else begin
          close_token();
          idle_char(c);
        end
      end
      SCAN_SLASH: begin
        if (c == CH_SLASH) begin
          scan_mode = SCAN_COMMENT;
        end else begin
          close_token();
          idle_char(c);
        end
      end
      SCAN_COMMENT: begin
        if (c == CH_LF) scan_mode = SCAN_IDLE;
      end
      default: begin
        scan_mode = SCAN_IDLE;
        idle_char(c);
      end
    endcase
    if (eot) begin
      if (scan_mode == SCAN_COMMENT) scan_mode = SCAN_IDLE;
      close_token();
    end
    if (byte_tok_cnt > 0) byte_toks[byte_tok_cnt-1].last = 1'b1;
    for (int i = 0; i < byte_tok_cnt; i++) tokens_due.push_back(byte_toks[i]);
  endtask

  always @(posedge clk) begin : watch
    cslx_pkg::tok_rec_t want;
    int                 bad;
    bad = 0;
    if (!rst_n) begin
      scan_mode = SCAN_IDLE;
      run_len   = 0;
      kw_cands  = cslx_pkg::ALL_CAND;
      ovf_seen  = 1'b0;
      tokens_due.delete();
      fail_count        <= 0;
      tokens_checked    <= 0;
      keywords_checked  <= 0;
      overflows_checked <= 0;
    end else begin
      if (in_tvalid && in_tready) scan_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (tokens_due.size() == 0) begin
          $error("token beat with nothing expected: kind %0d tdata %h", out_tuser, out_tdata);
          bad = 1;
        end else begin
          want = tokens_due.pop_front();
          bad += diff_field("token_kind", want.kind, out_tuser);
          bad += diff_field("keyword_index", want.kw_idx, out_tdata[3:0]);
          bad += diff_field("token_length", want.len, out_tdata[10:4]);
          bad += diff_field("symbol_char", want.sym, out_tdata[18:11]);
          bad += diff_field("length_overflow", want.ovf, out_tdata[19]);
          bad += diff_field("tdata_pad", 0, out_tdata[23:20]);
          bad += diff_field("last_of_run", want.last, out_tlast);
          tokens_checked    <= tokens_checked + 1;
          keywords_checked  <= keywords_checked +
                               int'(want.kind == cslx_pkg::KIND_KEYWORD);
          overflows_checked <= overflows_checked + int'(want.ovf);
        end
      end
      fail_count <= fail_count + bad;
    end
    tokens_pending <= tokens_due.size();
  end

endmodule

>>> verif/c_subset_lexer_test.sv
// Testbench top for the C subset lexer: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module c_subset_lexer_test;

  localparam int MAX_LEN      = 64;
  localparam int TOTAL_BYTES  = 1300;
  localparam int QUIET_FROM   = 1100;
  localparam int CYCLE_LIMIT  = 300000;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] SYMBOL_CHARS [8] = '{"+", "-", "*", "(", ")", "{", "}", "/"};

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  int fail_count;
  int tokens_pending;
  int tokens_checked;
  int keywords_checked;
  int overflows_checked;

  int bytes_sent   = 0;
  int texts_sent   = 0;
  int cycle_count  = 0;
  int sink_stall   = 0;
  bit gaps_on      = 1'b0;

  logic [7:0] text_q [$];

  c_subset_lexer #(
    .MAX_TOKEN_LEN (MAX_LEN)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  cslx_token_checker #(
    .MAX_TOKEN_LEN (MAX_LEN)
  ) i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_tvalid         (in_tvalid),
    .in_tready         (in_tready),
    .in_tdata          (in_tdata),
    .in_tlast          (in_tlast),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_tdata         (out_tdata),
    .out_tuser         (out_tuser),
    .out_tlast         (out_tlast),
    .fail_count        (fail_count),
    .tokens_pending    (tokens_pending),
    .tokens_checked    (tokens_checked),
    .keywords_checked  (keywords_checked),
    .overflows_checked (overflows_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // token sink: random stall bursts while gaps are on
  always @(posedge clk) begin
    if (sink_stall > 0) begin
      out_tready <= 1'b0;
      sink_stall <= sink_stall - 1;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      sink_stall <= $urandom_range(0, 3);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_byte(logic [7:0] c, logic eot);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= eot;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    if (eot) texts_sent++;
  endtask

  // send the built text, end_of_text on its final byte
  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'(8'h61 + r);
    if (r < 52) return 8'(8'h41 + r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(8'h30 + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_word_char();
    if ($urandom_range(0, 3) == 0) return rand_digit();
    return rand_letter();
  endfunction

  // mostly short runs, now and then one around the length limit
  function automatic int pick_len();
    if ($urandom_range(0, 39) == 0) return $urandom_range(MAX_LEN - 3, MAX_LEN + 8);
    return $urandom_range(1, 8);
  endfunction

  // keyword, or a near miss: truncated, one letter changed, case flipped, extended
  task automatic add_keyword();
    int         k;
    int         n;
    int         variant;
    logic [7:0] ch;
    k       = $urandom_range(0, cslx_pkg::NUM_KW - 1);
    variant = $urandom_range(0, 7);
    n       = int'(cslx_pkg::KW_LEN[k]);
    if (variant == 4 && n > 1) n--;
    for (int p = 0; p < n; p++) begin
      ch = cslx_pkg::KW_TEXT[k][p];
      if (variant == 5 && p == n - 1) ch = rand_letter();
      if (variant == 6 && p == 0) ch = ch ^ 8'h20;
      text_q.push_back(ch);
    end
    if (variant == 7) text_q.push_back(rand_word_char());
  endtask

  task automatic add_word(int len);
    text_q.push_back(rand_letter());
    repeat (len - 1) text_q.push_back(rand_word_char());
  endtask

  task automatic add_number(int len);
    repeat (len) text_q.push_back(rand_digit());
  endtask

  task automatic add_comment();
    logic [7:0] b;
    text_q.push_back("/");
    text_q.push_back("/");
    repeat ($urandom_range(0, 10)) begin
      b = 8'($urandom_range(0, 255));
      if (b == CH_LF) b = CH_SPACE;
      text_q.push_back(b);
    end
    text_q.push_back(CH_LF);
  endtask

  task automatic add_separator();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) text_q.push_back(CH_SPACE);
    else if (r < 4) text_q.push_back(CH_TAB);
    else if (r < 6) text_q.push_back(CH_LF);
    else if (r < 7) text_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic build_text();
    int pick;
    repeat ($urandom_range(1, 24)) begin
      pick = $urandom_range(0, 19);
      if (pick < 6) add_keyword();
      else if (pick < 10) add_word(pick_len());
      else if (pick < 13) add_number(pick_len());
      else if (pick < 17) text_q.push_back(SYMBOL_CHARS[$urandom_range(0, 7)]);
      else if (pick < 19) add_comment();
      else text_q.push_back(8'($urandom_range(0, 255)));
      add_separator();
    end
    // often end the text right on a token byte, a held slash or inside a comment
    if ($urandom_range(0, 1) == 0 && text_q.size() > 1) void'(text_q.pop_back());
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gaps_on = 1'b1;

    // byte extremes, keyword, symbols, word and number split by a dropped byte,
    // held slash before a letter, comment to newline, held slash at end of text
    text_q = '{8'h00, "i", "f", "(", "a", "1", 8'hFF, "7", "+", "/", "x", CH_TAB,
               "/", "/", "z", CH_LF, "/"};
    send_text();
    // text ends inside a comment
    text_q = '{"/", "/", "q"};
    send_text();
    // keyword match is case sensitive
    text_q = '{"I", "n", "t"};
    send_text();
    text_q = '{"}"};
    send_text();

    while (bytes_sent < TOTAL_BYTES) begin
      if (bytes_sent >= QUIET_FROM) gaps_on = 1'b0;
      else if ($urandom_range(0, 5) == 0) gaps_on = !gaps_on;
      build_text();
      send_text();
    end
    in_tvalid <= 1'b0;

    do @(posedge clk); while (tokens_pending != 0);
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes in %0d texts: words, numbers, symbols, comments, noise bytes.",
             bytes_sent, texts_sent);
    $display("Checked %0d token beats, %0d keywords, %0d with length overflow.",
             tokens_checked, keywords_checked, overflows_checked);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
